// ===== rtl/cev_pkg.sv =====
package cev_pkg;

  localparam int unsigned HEAD_DEPTH = 9;
  localparam int unsigned COUNT_W    = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] WRAP_B0     = 8'h31;
  localparam logic [7:0] WRAP_B1     = 8'h60;
  localparam logic [7:0] MAGIC       = 8'hFF;
  localparam logic [7:0] CMD_BUTTON  = 8'h22;
  localparam logic [7:0] CMD_KNOB    = 8'h24;
  localparam logic [7:0] LEN_BUTTON  = 8'h03;
  localparam logic [7:0] LEN_KNOB    = 8'h02;
  localparam logic [7:0] STATE_PRESS = 8'h01;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_KNOB   = 2'd2;

  // One finished packet as handed from the front to the back.
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [COUNT_W-1:0]         count;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/cev_if.sv =====
interface cev_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

interface cev_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [7:0]        control_id;
  logic              pressed;
  logic signed [5:0] delta;

  modport source (output valid, output event_kind, output control_id, output pressed,
                  output delta, input ready);
  modport sink (input valid, input event_kind, input control_id, input pressed,
                input delta, output ready);
endinterface

// ===== rtl/control_event_deframer_top.sv =====
// Channel   Dir  Payload                                   Handshake
// in_chan   in   data_byte[7:0], packet_end                valid/ready
// out_chan  out  event_kind[1:0], control_id[7:0],         valid/ready
//                pressed, delta[5:0] (signed)
//
// One byte is accepted per cycle while the hand-off queue is not full; bytes that
// do not close a packet are always taken unless it is full, and the front never
// waits on them. After a packet's last byte, the captured head is moved into the
// two-entry queue, and from there it is classified into the output register.
// Reset clears the byte count, the queue and the output valid.
// When the sink stalls, the queue absorbs up to two finished packets before
// the input side sees ready drop.
module control_event_deframer_top (
  input logic        clk,
  input logic        rst_n,
  cev_in_if.sink     in_chan,
  cev_out_if.source  out_chan
);

  // The front captures the first nine bytes and the saturating count; on the
  // closing byte it hands a snapshot of the whole head to the queue.
  cev_pkg::frame_t     push_frame;
  cev_pkg::frame_t     pop_frame;
  cev_pkg::fifo_stat_t stat;
  logic                push;
  logic                pop;

  cev_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .stat    (stat),
    .push    (push),
    .frame   (push_frame)
  );

  // The queue decouples byte capture from classification so that either side
  // may stall on its own.
  cev_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_frame (push_frame),
    .pop      (pop),
    .rd_frame (pop_frame),
    .stat     (stat)
  );

  // The back strips the optional wrapper, checks magic, command, length and
  // checksum, and registers the result for the output channel.
  cev_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .frame    (pop_frame),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // The front must never write a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
    else $error("push into full queue");

  // The back must never read an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
    else $error("pop from empty queue");

  // A rejected packet carries an all-zero payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.event_kind == cev_pkg::KIND_NONE) |->
      (out_chan.control_id == 8'h00 && !out_chan.pressed && out_chan.delta == 6'sd0))
    else $error("nonzero payload on empty event");

  // Each accepted closing byte reaches the queue in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.packet_end) |-> push)
    else $error("closing byte not queued");

endmodule

// ===== rtl/cev_front.sv =====
module cev_front (
  input  logic               clk,
  input  logic               rst_n,
  cev_in_if.sink             in_chan,
  input  cev_pkg::fifo_stat_t stat,
  output logic               push,
  output cev_pkg::frame_t    frame
);

  logic [cev_pkg::HEAD_DEPTH-1:0][7:0] head_r, head_nxt;
  logic [cev_pkg::COUNT_W-1:0]         count_r, count_nxt, count_inc;
  logic                                accept;

  // A byte is taken whenever the queue has room; ready looks at the queue
  // only, so it never waits on the payload.
  assign in_chan.ready = !stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && in_chan.packet_end;

  assign count_inc = (count_r != cev_pkg::COUNT_MAX) ? count_r + 1'b1 : count_r;

  always_comb begin
    for (int i = 0; i < cev_pkg::HEAD_DEPTH; i++) begin
      head_nxt[i] = (count_r == cev_pkg::COUNT_W'(i)) ? in_chan.data_byte : head_r[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_chan.packet_end ? '0 : count_inc;
    end
  end

  assign frame.head  = head_nxt;
  assign frame.count = count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
    end
  end

endmodule

// ===== rtl/cev_fifo.sv =====
module cev_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cev_pkg::frame_t     wr_frame,
  input  logic                pop,
  output cev_pkg::frame_t     rd_frame,
  output cev_pkg::fifo_stat_t stat
);

  cev_pkg::frame_t                 slot_r [cev_pkg::FIFO_DEPTH];
  logic [cev_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cev_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cev_pkg::FIFO_AW:0]       fill_r, fill_nxt;

  assign stat.full  = (fill_r == (cev_pkg::FIFO_AW+1)'(cev_pkg::FIFO_DEPTH));
  assign stat.empty = (fill_r == '0);
  assign rd_frame   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cev_pkg::FIFO_AW'(cev_pkg::FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cev_pkg::FIFO_AW'(cev_pkg::FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_frame;
    end
  end

endmodule

// ===== rtl/cev_back.sv =====
module cev_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cev_pkg::fifo_stat_t stat,
  input  cev_pkg::frame_t     frame,
  output logic                pop,
  cev_out_if.source           out_chan
);

  logic [7:0] f [7];
  logic       wrapped;
  logic [cev_pkg::COUNT_W-1:0] need_button, need_knob;
  logic [7:0] sum_knob, sum_button;
  logic       is_button, is_knob;

  logic              valid_r, valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        id_r, id_nxt;
  logic              pressed_r, pressed_nxt;
  logic signed [5:0] delta_r, delta_nxt;

  // The 31 60 wrapper shifts the frame by two bytes when FF follows it.
  assign wrapped = (frame.count >= cev_pkg::COUNT_W'(3)) &&
                   (frame.head[0] == cev_pkg::WRAP_B0) &&
                   (frame.head[1] == cev_pkg::WRAP_B1) &&
                   (frame.head[2] == cev_pkg::MAGIC);

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      f[i] = wrapped ? frame.head[i+2] : frame.head[i];
    end
  end

  assign need_button = wrapped ? cev_pkg::COUNT_W'(9) : cev_pkg::COUNT_W'(7);
  assign need_knob   = wrapped ? cev_pkg::COUNT_W'(8) : cev_pkg::COUNT_W'(6);

  assign sum_knob   = f[1] + f[2] + f[3] + f[4];
  assign sum_button = sum_knob + f[5];

  assign is_button = (frame.count >= need_button) && (f[0] == cev_pkg::MAGIC) &&
                     (f[1] == cev_pkg::CMD_BUTTON) && (f[2] == cev_pkg::LEN_BUTTON) &&
                     (f[4] == 8'h00) && (sum_button == f[6]);
  assign is_knob   = (frame.count >= need_knob) && (f[0] == cev_pkg::MAGIC) &&
                     (f[1] == cev_pkg::CMD_KNOB) && (f[2] == cev_pkg::LEN_KNOB) &&
                     (sum_knob == f[5]);

  assign pop = !stat.empty && (!valid_r || out_chan.ready);

  always_comb begin
    valid_nxt   = valid_r && !out_chan.ready;
    kind_nxt    = kind_r;
    id_nxt      = id_r;
    pressed_nxt = pressed_r;
    delta_nxt   = delta_r;
    if (pop) begin
      valid_nxt   = 1'b1;
      kind_nxt    = cev_pkg::KIND_NONE;
      id_nxt      = '0;
      pressed_nxt = 1'b0;
      delta_nxt   = '0;
      if (is_button) begin
        kind_nxt    = cev_pkg::KIND_BUTTON;
        id_nxt      = f[3];
        pressed_nxt = (f[5] == cev_pkg::STATE_PRESS);
      end else if (is_knob) begin
        kind_nxt  = cev_pkg::KIND_KNOB;
        id_nxt    = f[3];
        delta_nxt = f[4][5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    id_r      <= id_nxt;
    pressed_r <= pressed_nxt;
    delta_r   <= delta_nxt;
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.event_kind = kind_r;
  assign out_chan.control_id = id_r;
  assign out_chan.pressed    = pressed_r;
  assign out_chan.delta      = delta_r;

endmodule
